### hw/rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Holds field widths, status and mode codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package spq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PRIO_W  = 16;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned ENTRY_W = VALUE_W + PRIO_W;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_PLACE = 4'b0100,
    S_REM   = 4'b1000
  } state_e;

  typedef struct packed {
    logic    ins_start;
    logic    rem_start;
    logic    shift;
    logic    place;
    logic    load_out;
    status_e out_code;
  } spq_cmd_t;

  typedef struct packed {
    logic out_free;
    logic full;
    logic empty;
    logic k_last;
    logic prio_gt;
  } spq_stat_t;

endpackage

### hw/rtl/spq_ctrl.sv
// Controller state machine of the sorted priority queue.
// Decodes accepted items and sequences the shift loop of the datapath.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t  cmd_o
);
  import spq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = !((state_q == S_IDLE) && stat_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{ins_start: 1'b0, rem_start: 1'b0, shift: 1'b0, place: 1'b0,
                load_out: 1'b0, out_code: ST_INSERTED};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_INSERT) begin
            if (stat_i.full) begin
              cmd_o.load_out = 1'b1;
              cmd_o.out_code = ST_OVERFLOW;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d = stat_i.empty ? S_PLACE : S_SHIFT;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.load_out = 1'b1;
              cmd_o.out_code = ST_UNDERFLOW;
            end else begin
              cmd_o.rem_start = 1'b1;
              state_d = S_REM;
            end
          end
        end
      end
      S_SHIFT: begin
        if (stat_i.prio_gt) begin
          cmd_o.shift = 1'b1;
          if (stat_i.k_last) begin
            state_d = S_PLACE;
          end
        end else begin
          cmd_o.place    = 1'b1;
          cmd_o.load_out = 1'b1;
          cmd_o.out_code = ST_INSERTED;
          state_d = S_IDLE;
        end
      end
      S_PLACE: begin
        cmd_o.place    = 1'b1;
        cmd_o.load_out = 1'b1;
        cmd_o.out_code = ST_INSERTED;
        state_d = S_IDLE;
      end
      S_REM: begin
        cmd_o.load_out = 1'b1;
        cmd_o.out_code = ST_REMOVED;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/spq_dp.sv
// Datapath of the sorted priority queue: entry memory kept as a sorted ring,
// head and tail pointers, fill count, shift pointers and the result register.
// Depends on spq_pkg.
module spq_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  spq_pkg::spq_cmd_t                    cmd_i,
  output spq_pkg::spq_stat_t                   stat_o,
  input  logic signed [spq_pkg::VALUE_W-1:0]   item_value_i,
  input  logic        [spq_pkg::PRIO_W-1:0]    item_priority_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [spq_pkg::VALUE_W-1:0]   out_value_o,
  output logic        [1:0]                    status_o,
  output logic        [spq_pkg::FILL_W-1:0]    fill_count_o
);
  import spq_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
    return (x == '0) ? IDX_W'(QUEUE_DEPTH - 1) : x - 1'b1;
  endfunction

  logic [ENTRY_W-1:0]       mem_q [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]       rd_q;
  logic [IDX_W-1:0]         head_q, tail_q, hole_q, ptr_q;
  logic [IDX_W-1:0]         raddr, waddr;
  logic [ENTRY_W-1:0]       wdata;
  logic                     we;
  logic [CNT_W-1:0]         count_q, k_q;
  logic [VALUE_W-1:0]       item_value_q;
  logic [PRIO_W-1:0]        item_prio_q;
  logic                     out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  status_e                  out_status_q;
  logic [FILL_W-1:0]        out_fill_q;
  logic [CNT_W+FILL_W-1:0]  count_ext;

  assign count_ext = {{FILL_W{1'b0}}, count_q};

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.k_last   = (k_q == CNT_W'(1));
  assign stat_o.prio_gt  = (rd_q[ENTRY_W-1:VALUE_W] > item_prio_q);

  always_comb begin
    if (cmd_i.rem_start) begin
      raddr = head_q;
    end else if (cmd_i.ins_start) begin
      raddr = idx_dec(tail_q);
    end else begin
      raddr = idx_dec(ptr_q);
    end
  end

  assign we    = cmd_i.shift || cmd_i.place;
  assign waddr = hole_q;
  assign wdata = cmd_i.shift ? rd_q : {item_prio_q, item_value_q};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_start) begin
      item_value_q <= item_value_i;
      item_prio_q  <= item_priority_i;
      hole_q       <= tail_q;
      ptr_q        <= idx_dec(tail_q);
      k_q          <= count_q;
    end else if (cmd_i.shift) begin
      hole_q <= ptr_q;
      ptr_q  <= idx_dec(ptr_q);
      k_q    <= k_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.ins_start) begin
      tail_q  <= idx_inc(tail_q);
      count_q <= count_q + 1'b1;
    end else if (cmd_i.rem_start) begin
      head_q  <= idx_inc(head_q);
      count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.out_code;
      out_fill_q   <= count_ext[FILL_W-1:0];
      if (cmd_i.out_code == ST_REMOVED) begin
        out_value_q <= $signed(rd_q[VALUE_W-1:0]);
      end else begin
        out_value_q <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign status_o     = out_status_q;
  assign fill_count_o = out_fill_q;

endmodule

### hw/rtl/sorted_priority_queue_core.sv
// Sorted priority queue top level: controller plus datapath with a sorted ring memory.
// Overflow and underflow results are registered in the cycle after the transfer. A remove
// reads the head entry, then loads it in S_REM; an insert moves S entries back one per
// cycle in S_SHIFT (S from 0 to QUEUE_DEPTH-1), then writes the item and loads the result.
// One item in work at a time; a new transfer waits for S_IDLE and for a stalled result.
// Reset empties the queue at once; memory contents are not cleared.
module sorted_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 mode_i,
  input  logic signed [spq_pkg::VALUE_W-1:0]   item_value_i,
  input  logic        [spq_pkg::PRIO_W-1:0]    item_priority_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [spq_pkg::VALUE_W-1:0]   out_value_o,
  output logic        [1:0]                    status_o,
  output logic        [spq_pkg::FILL_W-1:0]    fill_count_o
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_value_o     (out_value_o),
    .status_o        (status_o),
    .fill_count_o    (fill_count_o)
  );

endmodule

### hw/rtl/spq_checker.sv
// Port-level checker for the sorted priority queue and its bind to the top level.
// Depends on spq_pkg.
module spq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [spq_pkg::VALUE_W-1:0] out_value_o,
  input logic        [1:0]                  status_o,
  input logic        [spq_pkg::FILL_W-1:0]  fill_count_o
);
  import spq_pkg::*;

  localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(QUEUE_DEPTH);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o)
      && $stable(status_o) && $stable(fill_count_o))
    else $error("Stalled result changed.");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_UNDERFLOW) |-> (fill_count_o == '0))
    else $error("Underflow reported with a nonzero fill count.");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OVERFLOW) |-> (fill_count_o == DEPTH_FILL))
    else $error("Overflow reported while the queue is not full.");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_REMOVED) |-> (out_value_o == '0))
    else $error("Nonzero value on a result that is not a remove.");

endmodule

bind sorted_priority_queue_core spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_value_o  (out_value_o),
  .status_o     (status_o),
  .fill_count_o (fill_count_o)
);
